### rtl/touch_phase_tracker_top_macros.svh
// Assertion macros for the touch phase tracker.
`ifndef TOUCH_PHASE_TRACKER_TOP_MACROS_SVH
`define TOUCH_PHASE_TRACKER_TOP_MACROS_SVH

// same-cycle implication
`define TPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tpt_pkg.sv
// Types and constants shared by the touch phase tracker modules.
`default_nettype none
package tpt_pkg;

    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = 1;
    localparam int FQ_CW    = 2;

    typedef enum logic [1:0] {
        PH_DOWN = 2'd0,
        PH_MOVE = 2'd1,
        PH_UP   = 2'd2
    } phase_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_SCAN = 1'b1
    } bk_state_t;

    typedef struct packed {
        logic        has_point;
        logic [7:0]  contact_id;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [47:0] frame_time_us;
        logic        frame_end;
    } item_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  event_id;
        logic [15:0] event_x;
        logic [15:0] event_y;
        logic [47:0] event_time_us;
        logic        last_event;
    } result_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] x;
        logic [15:0] y;
    } contact_t;

    typedef struct packed {
        logic scanning;
        logic pending_any;
        logic deq;
    } bk_status_t;

endpackage
`default_nettype wire

### rtl/tpt_front.sv
// Front end: takes requests, drops no-op items, queues the rest for the back end.
`default_nettype none
module tpt_front
    import tpt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t item,
    output logic       full,
    output logic       cmd_valid,
    output item_t      cmd,
    input  wire logic  deq,
    output logic [FQ_CW-1:0] count
);

    item_t             q_reg [FQ_DEPTH];
    logic [FQ_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FQ_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FQ_CW-1:0]  count_reg, count_next;
    logic              enq;
    logic              pop_q;

    assign full      = (count_reg == FQ_CW'(FQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign count     = count_reg;

    // items with neither a point nor a frame end cause nothing
    assign enq   = push && !full && (item.has_point || item.frame_end);
    assign pop_q = deq && cmd_valid;

    always_comb
    begin
        wr_ptr_next = enq   ? wr_ptr_reg + FQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop_q ? rd_ptr_reg + FQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !pop_q)
        begin
            count_next = count_reg + FQ_CW'(1);
        end
        else if (!enq && pop_q)
        begin
            count_next = count_reg - FQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

endmodule
`default_nettype wire

### rtl/tpt_back.sv
// Back end: contact tables, id lookup, up-event scan and result register.
`default_nettype none
module tpt_back
    import tpt_pkg::*;
#(
    parameter int MAX_POINTS = 5
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cmd_valid,
    input  wire item_t cmd,
    output logic       deq,
    output logic       empty,
    input  wire logic  pop,
    output result_t    result,
    output bk_status_t status
);

    localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int FILL_W = $clog2(MAX_POINTS + 1);

    contact_t                prev_tab_reg [MAX_POINTS];
    contact_t                cur_tab_reg  [MAX_POINTS];
    contact_t                cur_tab_upd  [MAX_POINTS];
    logic [MAX_POINTS-1:0]   prev_act_reg;
    logic [MAX_POINTS-1:0]   cur_act_reg;
    logic [MAX_POINTS-1:0]   cur_act_upd;
    logic [MAX_POINTS-1:0]   seen_reg, seen_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [47:0]             time_reg, time_next;
    bk_state_t               state_reg, state_next;
    result_t                 out_reg;
    logic                    out_valid_reg, out_valid_next;

    logic [MAX_POINTS-1:0]   hit;
    logic                    found;
    logic                    take_point;
    logic [MAX_POINTS-1:0]   pend_now;
    logic [MAX_POINTS-1:0]   pend_scan;
    logic                    more_above;
    logic                    out_free;
    logic                    emit;
    logic                    wr_cur;
    logic                    do_copy;
    result_t                 ev;

    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign out_free = !out_valid_reg || pop;

    // first active previous entry with the same id
    always_comb
    begin
        hit   = '0;
        found = 1'b0;
        for (int j = 0; j < MAX_POINTS; j++)
        begin
            if (!found && prev_act_reg[j] && prev_tab_reg[j].id == cmd.contact_id)
            begin
                hit[j] = 1'b1;
                found  = 1'b1;
            end
        end
    end

    assign take_point = cmd.has_point && (fill_reg < FILL_W'(MAX_POINTS));
    assign pend_now   = prev_act_reg & ~seen_reg & ~(take_point ? hit : '0);
    assign pend_scan  = prev_act_reg & ~seen_reg;

    always_comb
    begin
        more_above = 1'b0;
        for (int j = 0; j < MAX_POINTS; j++)
        begin
            if (j > int'(idx_reg))
            begin
                more_above = more_above | pend_scan[j];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        time_next  = time_reg;
        seen_next  = seen_reg;
        fill_next  = fill_reg;
        deq        = 1'b0;
        emit       = 1'b0;
        wr_cur     = 1'b0;
        do_copy    = 1'b0;
        ev         = '0;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && (!take_point || out_free))
                begin
                    deq = 1'b1;
                    if (take_point)
                    begin
                        emit             = 1'b1;
                        wr_cur           = 1'b1;
                        ev.phase         = found ? PH_MOVE : PH_DOWN;
                        ev.event_id      = cmd.contact_id;
                        ev.event_x       = cmd.pos_x;
                        ev.event_y       = cmd.pos_y;
                        ev.event_time_us = cmd.frame_time_us;
                        ev.last_event    = !cmd.frame_end || (pend_now == '0);
                        seen_next        = seen_reg | hit;
                        fill_next        = fill_reg + FILL_W'(1);
                    end
                    if (cmd.frame_end)
                    begin
                        if (pend_now != '0)
                        begin
                            state_next = BK_SCAN;
                            idx_next   = '0;
                            time_next  = cmd.frame_time_us;
                        end
                        else
                        begin
                            do_copy = 1'b1;
                        end
                    end
                end
            end
            BK_SCAN:
            begin
                if (pend_scan[idx_reg])
                begin
                    if (out_free)
                    begin
                        emit             = 1'b1;
                        ev.phase         = PH_UP;
                        ev.event_id      = prev_tab_reg[idx_reg].id;
                        ev.event_x       = prev_tab_reg[idx_reg].x;
                        ev.event_y       = prev_tab_reg[idx_reg].y;
                        ev.event_time_us = time_reg;
                        ev.last_event    = !more_above;
                        if (!more_above)
                        begin
                            do_copy    = 1'b1;
                            state_next = BK_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        if (do_copy)
        begin
            seen_next = '0;
            fill_next = '0;
        end
        out_valid_next = emit ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    // open frame table including this cycle's point
    always_comb
    begin
        for (int j = 0; j < MAX_POINTS; j++)
        begin
            cur_tab_upd[j] = cur_tab_reg[j];
            cur_act_upd[j] = cur_act_reg[j];
            if (wr_cur && fill_reg[IDX_W-1:0] == IDX_W'(j))
            begin
                cur_tab_upd[j].id = cmd.contact_id;
                cur_tab_upd[j].x  = cmd.pos_x;
                cur_tab_upd[j].y  = cmd.pos_y;
                cur_act_upd[j]    = 1'b1;
            end
        end
    end

    assign status.scanning    = (state_reg == BK_SCAN);
    assign status.pending_any = (pend_scan != '0);
    assign status.deq         = deq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            prev_act_reg  <= '0;
            cur_act_reg   <= '0;
            seen_reg      <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (do_copy)
            begin
                prev_act_reg <= cur_act_upd;
                cur_act_reg  <= '0;
            end
            else
            begin
                cur_act_reg  <= cur_act_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        if (emit)
        begin
            out_reg <= ev;
        end
        for (int j = 0; j < MAX_POINTS; j++)
        begin
            cur_tab_reg[j] <= cur_tab_upd[j];
            if (do_copy)
            begin
                prev_tab_reg[j] <= cur_tab_upd[j];
            end
        end
    end

endmodule
`default_nettype wire

### rtl/touch_phase_tracker_top.sv
// Touch phase tracker: turns per-frame contact reports into down/move/up events.
//
// Input queue: drive item and raise push; a request is taken on a clock edge
// with push high and full low. One request is one contact point or a frame end
// mark (an empty frame is a request with has_point low and frame_end high).
// Result queue: while empty is low the oldest event is on result; pop takes it.
// last_event marks the final event caused by one input request.
// A two-entry input queue feeds the back end, which keeps MAX_POINTS contacts.
// With both sides idle, a point's event passes through the input queue and then the
// result register, and points can follow one per cycle while results are popped.
// A frame end with unseen previous contacts starts a scan of the previous table, one
// entry per cycle, holding on a pending entry while the result register is full, and
// emits one up event per unseen contact in index order.
// Points past MAX_POINTS in a frame are dropped with no event.
// A stalled result register holds the back end; the input queue still takes up
// to two requests, then raises full.
// Reset clears both tables, the seen mask, the fill count and both queues.
`default_nettype none
module touch_phase_tracker_top
    import tpt_pkg::*;
#(
    parameter int MAX_POINTS = 5
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t item,
    output logic       full,
    output logic       empty,
    input  wire logic  pop,
    output result_t    result
);

`include "touch_phase_tracker_top_macros.svh"

    logic             cmd_valid;
    item_t            cmd;
    logic             deq;
    logic [FQ_CW-1:0] fq_count;
    bk_status_t       bk_status;

    tpt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .deq       (deq),
        .count     (fq_count)
    );

    tpt_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .deq       (deq),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .status    (bk_status)
    );

    `TPT_ASSERT_NEXT(a_accept_queued, push && !full && (item.has_point || item.frame_end),
        fq_count != '0, "accepted request not queued")
    `TPT_ASSERT_NOW(a_scan_pending, bk_status.scanning, bk_status.pending_any,
        "up scan running with no pending contact")
    `TPT_ASSERT_NOW(a_scan_no_deq, bk_status.scanning, !bk_status.deq,
        "request taken during up scan")

endmodule
`default_nettype wire

### tb/tpt_tb_pkg.sv
// Event predictor and scoreboard class for the touch phase tracker testbench.
package tpt_tb_pkg;
    import tpt_pkg::*;

    localparam int TRACK_DEPTH = 5;

    class touch_event_ledger;
        contact_t             last_frame [TRACK_DEPTH];
        bit                   last_live  [TRACK_DEPTH];
        contact_t             open_frame [TRACK_DEPTH];
        bit                   open_live  [TRACK_DEPTH];
        bit [TRACK_DEPTH-1:0] hit_mask;
        int                   open_fill;
        result_t              pending_events [$];
        int                   requests;
        int                   frames;
        int                   mismatches;
        int                   phase_count [3];

        function new();
            foreach (last_frame[i])
            begin
                last_frame[i] = '0;
                open_frame[i] = '0;
                last_live[i]  = 1'b0;
                open_live[i]  = 1'b0;
            end
            hit_mask  = '0;
            open_fill = 0;
        endfunction

        // Works out the events one accepted request causes.
        function void take_request(item_t rq);
            result_t ev;
            result_t batch [$];
            bit      hit;
            int      i;
            requests++;
            hit = 1'b0;
            if (rq.has_point && open_fill < TRACK_DEPTH)
            begin
                ev = '0;
                ev.phase = PH_DOWN;
                ev.event_id = rq.contact_id;
                ev.event_x = rq.pos_x;
                ev.event_y = rq.pos_y;
                ev.event_time_us = rq.frame_time_us;
                for (i = 0; i < TRACK_DEPTH; i++)
                begin
                    if (!hit && last_live[i] && last_frame[i].id == rq.contact_id)
                    begin
                        hit = 1'b1;
                        hit_mask[i] = 1'b1;
                        ev.phase = PH_MOVE;
                    end
                end
                batch.push_back(ev);
                open_frame[open_fill].id = rq.contact_id;
                open_frame[open_fill].x = rq.pos_x;
                open_frame[open_fill].y = rq.pos_y;
                open_live[open_fill] = 1'b1;
                open_fill++;
            end
            if (rq.frame_end)
            begin
                frames++;
                for (i = 0; i < TRACK_DEPTH; i++)
                begin
                    if (last_live[i] && !hit_mask[i])
                    begin
                        ev = '0;
                        ev.phase = PH_UP;
                        ev.event_id = last_frame[i].id;
                        ev.event_x = last_frame[i].x;
                        ev.event_y = last_frame[i].y;
                        ev.event_time_us = rq.frame_time_us;
                        batch.push_back(ev);
                    end
                end
                last_frame = open_frame;
                last_live = open_live;
                for (i = 0; i < TRACK_DEPTH; i++)
                begin
                    open_frame[i] = '0;
                    open_live[i] = 1'b0;
                end
                hit_mask = '0;
                open_fill = 0;
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last_event = 1'b1;
            foreach (batch[k])
                pending_events.push_back(batch[k]);
        endfunction

        function void match_event(result_t got);
            result_t want;
            if (pending_events.size() == 0)
            begin
                $error("unexpected event: phase %0d id %0d", got.phase, got.event_id);
                mismatches++;
            end
            else
            begin
                want = pending_events.pop_front();
                phase_count[int'(want.phase)]++;
                if (got.phase !== want.phase)
                begin
                    $error("phase: expected %0d, got %0d", want.phase, got.phase);
                    mismatches++;
                end
                if (got.event_id !== want.event_id)
                begin
                    $error("event_id: expected %0d, got %0d", want.event_id, got.event_id);
                    mismatches++;
                end
                if (got.event_x !== want.event_x)
                begin
                    $error("event_x: expected %0d, got %0d", want.event_x, got.event_x);
                    mismatches++;
                end
                if (got.event_y !== want.event_y)
                begin
                    $error("event_y: expected %0d, got %0d", want.event_y, got.event_y);
                    mismatches++;
                end
                if (got.event_time_us !== want.event_time_us)
                begin
                    $error("event_time_us: expected %0h, got %0h",
                           want.event_time_us, got.event_time_us);
                    mismatches++;
                end
                if (got.last_event !== want.last_event)
                begin
                    $error("last_event: expected %0d, got %0d",
                           want.last_event, got.last_event);
                    mismatches++;
                end
            end
        endfunction
    endclass

endpackage

### tb/tb.sv
// Top-level testbench for the touch phase tracker: directed frames, then random frames.
module tb;
    import tpt_pkg::*;
    import tpt_tb_pkg::*;

    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_REQUESTS = 40;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    push = 1'b0;
    item_t   item = '0;
    logic    pop = 1'b0;
    logic    full;
    logic    empty;
    result_t result;

    touch_event_ledger ledger;
    int       send_gap_pct = 0;
    int       take_gap_pct = 0;
    int       stall_cycles = 0;
    int       sent;
    bit [7:0] live_ids [$];

    touch_phase_tracker_top #(.MAX_POINTS(TRACK_DEPTH)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .item(item),
        .full(full),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                ledger.match_event(result);
            pop <= ($urandom_range(99) >= take_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("timeout: no request or event moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic item_t mk_item(bit hp, bit [7:0] id, bit [15:0] x, bit [15:0] y,
                                      bit [47:0] stamp, bit fe);
        item_t it;
        it.has_point = hp;
        it.contact_id = id;
        it.pos_x = x;
        it.pos_y = y;
        it.frame_time_us = stamp;
        it.frame_end = fe;
        return it;
    endfunction

    task automatic send(item_t it);
        while ($urandom_range(99) < send_gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        ledger.take_request(it);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do
            @(posedge clk);
        while (ledger.pending_events.size() != 0);
    endtask

    // One report frame; sometimes over-full, sometimes closed by a separate empty request.
    task automatic random_frame();
        int        npts;
        int        pick;
        int        k;
        bit [47:0] stamp;
        bit [7:0]  id;
        bit        split_end;
        bit [7:0]  fresh [$];
        stamp = {16'($urandom), $urandom()};
        pick = $urandom_range(99);
        npts = (pick < 10) ? 0 : (pick < 88) ? $urandom_range(1, 5) : $urandom_range(6, 7);
        split_end = ($urandom_range(99) < 12);
        if (npts == 0)
        begin
            send(mk_item(1'b0, 8'($urandom), 16'($urandom), 16'($urandom), stamp, 1'b1));
            sent++;
        end
        for (k = 0; k < npts; k++)
        begin
            if ($urandom_range(99) < 8)
                send(mk_item(1'b0, 8'($urandom), 16'($urandom), 16'($urandom),
                             {16'($urandom), $urandom()}, 1'b0));
            if (live_ids.size() > 0 && $urandom_range(99) < 65)
                id = live_ids[$urandom_range(live_ids.size() - 1)];
            else if ($urandom_range(1) == 1)
                id = 8'($urandom_range(15));
            else
                id = 8'($urandom_range(255));
            if (k < TRACK_DEPTH)
                fresh.push_back(id);
            send(mk_item(1'b1, id, 16'($urandom), 16'($urandom), stamp,
                         (k == npts - 1) && !split_end));
            sent++;
        end
        if (npts > 0 && split_end)
        begin
            send(mk_item(1'b0, 8'($urandom), 16'($urandom), 16'($urandom), stamp, 1'b1));
            sent++;
        end
        live_ids = fresh;
    endtask

    task automatic random_phase(int send_gap, int take_gap);
        send_gap_pct = send_gap;
        take_gap_pct = take_gap;
        sent = 0;
        while (sent < PHASE_REQUESTS)
            random_frame();
    endtask

    initial
    begin
        ledger = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty frame with nothing tracked
        send(mk_item(1'b0, 8'h00, 16'h0000, 16'h0000, 48'h0, 1'b1));
        // two downs at the coordinate extremes
        send(mk_item(1'b1, 8'h00, 16'h0000, 16'h0000, 48'hFFFF_FFFF_FFFF, 1'b0));
        send(mk_item(1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b1));
        // move, ignored empty request, repeated id, new id, up for id 0
        send(mk_item(1'b1, 8'hFF, 16'h1234, 16'h5678, 48'h1, 1'b0));
        send(mk_item(1'b0, 8'h5A, 16'hAAAA, 16'h5555, 48'hABCD_EF01_2345, 1'b0));
        send(mk_item(1'b1, 8'hFF, 16'h1235, 16'h5679, 48'h1, 1'b0));
        send(mk_item(1'b1, 8'h07, 16'h0100, 16'h0200, 48'h1, 1'b1));
        // hit on the first of two equal ids; the second one and id 7 go up
        send(mk_item(1'b1, 8'hFF, 16'h0300, 16'h0300, 48'h2, 1'b1));
        // table full: sixth point dropped, frame end still handled
        for (int i = 1; i <= 6; i++)
            send(mk_item(1'b1, 8'(i), 16'(i * 100), 16'(i * 200), 48'h3, i == 6));
        // one down plus five ups
        send(mk_item(1'b1, 8'hC8, 16'h8000, 16'h7FFF, 48'h8000_0000_0000, 1'b1));
        send(mk_item(1'b0, 8'h00, 16'h0000, 16'h0000, 48'h4, 1'b1));
        send(mk_item(1'b0, 8'h00, 16'h0000, 16'h0000, 48'h5, 1'b1));

        random_phase(35, 74);
        wait_drained();
        random_phase(74, 35);
        random_phase(0, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests in %0d frames, sender/receiver gaps in both mixes",
                 ledger.requests, ledger.frames);
        $display("events checked: %0d down, %0d move, %0d up",
                 ledger.phase_count[0], ledger.phase_count[1], ledger.phase_count[2]);
        if (ledger.mismatches == 0 && ledger.pending_events.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### touch_phase_tracker_top.f
+incdir+rtl
rtl/tpt_pkg.sv
rtl/tpt_front.sv
rtl/tpt_back.sv
rtl/touch_phase_tracker_top.sv
tb/tpt_tb_pkg.sv
tb/tb.sv
